/* src/rdr_pkg.sv */
// ----------------------------------------------------------------------------
// rdr_pkg
// Shared types and register codes of the radial distortion residual unit.
// ----------------------------------------------------------------------------
package rdr_pkg;

    // pipeline advance and item valid, handed to the sqrt pipelines
    typedef struct packed {
        logic en;
        logic valid;
    } rdr_step_t;

    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_HEIGHT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_X     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_Y     = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HUBER_SIGMA = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFFS_0    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFFS_1    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFFS_2    = 4'd7;

endpackage

/* src/rdr_isqrt.sv */
// ----------------------------------------------------------------------------
// rdr_isqrt
// Pipelined integer square root, one result bit per stage, with side payload.
// ----------------------------------------------------------------------------
module rdr_isqrt #(
    parameter int ROOT_W = 22,
    parameter int PAY_W  = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rdr_pkg::rdr_step_t      in_step,
    input  logic [2*ROOT_W-1:0]     in_radicand,
    input  logic [PAY_W-1:0]        in_pay,
    output logic                    out_valid,
    output logic [ROOT_W-1:0]       out_root,
    output logic [PAY_W-1:0]        out_pay
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              vld_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [PAY_W-1:0]  pay_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              vld_src;
        logic [RAD_W-1:0]  rad_src;
        logic [REM_W-1:0]  rem_src;
        logic [ROOT_W-1:0] root_src;
        logic [PAY_W-1:0]  pay_src;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;

        if (k == 0) begin : g_first
            assign vld_src  = in_step.valid;
            assign rad_src  = in_radicand;
            assign rem_src  = '0;
            assign root_src = '0;
            assign pay_src  = in_pay;
        end else begin : g_next
            assign vld_src  = vld_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign pay_src  = pay_reg[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_sh = {rem_src[ROOT_W-1:0], rad_src[RAD_W-1 -: 2]};
        assign trial  = {root_src, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (in_step.en) begin
                vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (in_step.en) begin
                rad_reg[k] <= rad_src << 2;
                pay_reg[k] <= pay_src;
                if (rem_sh >= trial) begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_src[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_src[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_pay   = pay_reg[ROOT_W-1];

endmodule

/* src/radial_distortion_residual_unit.sv */
// ----------------------------------------------------------------------------
// radial_distortion_residual_unit
// Radius of both points, normalise, quartic radial polynomial, Huber residual.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock. It is built from the two bit-per-stage
// square root pipelines (22 stages for the radii, 30 for the Huber weight),
// the 24-stage quotient of the radius normalisation and three stages per
// Horner step. The whole pipeline holds while a result waits at the output;
// the input is ready whenever the output register is empty or being taken.
// Coefficients and geometry registers must only be written while no item is in
// flight.
// ----------------------------------------------------------------------------
module radial_distortion_residual_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // cfg_data: register value, low bits used per register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rdr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: first_x[19:0], first_y[39:20], second_x[59:40], second_y[79:60]
    input  logic [79:0] s_tdata,
    // s_tuser: first_image[1:0], second_image[3:2]
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: residual[23:0], abs_error[46:24], zero[47]
    output logic [47:0] m_tdata
);

    localparam int RW = 22;          // radius width
    localparam int HW = 30;          // Huber root width
    localparam int QW = 24;          // normalised radius width
    localparam logic signed [48:0] ACC_HI = 49'sd274877906943;
    localparam logic signed [48:0] ACC_LO = -49'sd274877906943;
    localparam logic [23:0] RES_MAX = 24'h7FFFFF;
    localparam logic [23:0] RES_MIN = 24'h800000;

    typedef struct packed {
        logic [QW-1:0] u;
        logic [1:0]    img;
        logic [RW-1:0] r_oth;
    } hside_t;

    // ---------------- configuration ----------------
    logic [18:0] half_width_reg, half_height_reg;
    logic [20:0] shift_x_reg, shift_y_reg;
    logic [15:0] huber_sigma_reg;
    logic [63:0] coeffs_reg [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= '0;
            half_height_reg <= '0;
            shift_x_reg     <= '0;
            shift_y_reg     <= '0;
            huber_sigma_reg <= '0;
            coeffs_reg[0]   <= 64'd4096;
            coeffs_reg[1]   <= 64'd4096;
            coeffs_reg[2]   <= 64'd4096;
        end else if (cfg_valid) begin
            case (cfg_index)
                rdr_pkg::REG_HALF_WIDTH:  half_width_reg  <= cfg_data[18:0];
                rdr_pkg::REG_HALF_HEIGHT: half_height_reg <= cfg_data[18:0];
                rdr_pkg::REG_SHIFT_X:     shift_x_reg     <= cfg_data[20:0];
                rdr_pkg::REG_SHIFT_Y:     shift_y_reg     <= cfg_data[20:0];
                rdr_pkg::REG_HUBER_SIGMA: huber_sigma_reg <= cfg_data[15:0];
                rdr_pkg::REG_COEFFS_0:    coeffs_reg[0]   <= cfg_data;
                rdr_pkg::REG_COEFFS_1:    coeffs_reg[1]   <= cfg_data;
                rdr_pkg::REG_COEFFS_2:    coeffs_reg[2]   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [21:0] cx, cy;
    logic [18:0] base;
    assign cx   = {3'b000, half_width_reg} + {shift_x_reg[20], shift_x_reg};
    assign cy   = {3'b000, half_height_reg} + {shift_y_reg[20], shift_y_reg};
    assign base = (half_width_reg < half_height_reg) ? half_width_reg : half_height_reg;

    // ---------------- flow control ----------------
    logic en;
    logic m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- stage A: offsets ----------------
    logic [22:0] dx1, dy1, dx2, dy2;
    assign dx1 = {3'b000, s_tdata[19:0]}  - {cx[21], cx};
    assign dy1 = {3'b000, s_tdata[39:20]} - {cy[21], cy};
    assign dx2 = {3'b000, s_tdata[59:40]} - {cx[21], cx};
    assign dy2 = {3'b000, s_tdata[79:60]} - {cy[21], cy};

    logic        a_vld_reg;
    logic [21:0] a_dx1_reg, a_dy1_reg, a_dx2_reg, a_dy2_reg;
    logic [1:0]  a_img1_reg, a_img2_reg;
    logic [22:0] ndx1, ndy1, ndx2, ndy2;
    assign ndx1 = -dx1;
    assign ndy1 = -dy1;
    assign ndx2 = -dx2;
    assign ndy2 = -dy2;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_dx1_reg  <= dx1[22] ? ndx1[21:0] : dx1[21:0];
            a_dy1_reg  <= dy1[22] ? ndy1[21:0] : dy1[21:0];
            a_dx2_reg  <= dx2[22] ? ndx2[21:0] : dx2[21:0];
            a_dy2_reg  <= dy2[22] ? ndy2[21:0] : dy2[21:0];
            a_img1_reg <= s_tuser[1:0];
            a_img2_reg <= s_tuser[3:2];
        end
    end

    // ---------------- stage B: squares ----------------
    logic        b_vld_reg;
    logic [43:0] b_x1_reg, b_y1_reg, b_x2_reg, b_y2_reg;
    logic [1:0]  b_img1_reg, b_img2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_x1_reg   <= a_dx1_reg * a_dx1_reg;
            b_y1_reg   <= a_dy1_reg * a_dy1_reg;
            b_x2_reg   <= a_dx2_reg * a_dx2_reg;
            b_y2_reg   <= a_dy2_reg * a_dy2_reg;
            b_img1_reg <= a_img1_reg;
            b_img2_reg <= a_img2_reg;
        end
    end

    // ---------------- stage C: sums, pick reference side ----------------
    logic        c_vld_reg;
    logic [43:0] c_ref_reg, c_oth_reg;
    logic [1:0]  c_img_reg;
    logic [43:0] sum1, sum2;
    assign sum1 = b_x1_reg + b_y1_reg;
    assign sum2 = b_x2_reg + b_y2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (b_img1_reg == 2'd1) begin
                c_ref_reg <= sum1;
                c_oth_reg <= sum2;
                c_img_reg <= b_img2_reg;
            end else begin
                c_ref_reg <= sum2;
                c_oth_reg <= sum1;
                c_img_reg <= b_img1_reg;
            end
        end
    end

    // ---------------- radii ----------------
    rdr_pkg::rdr_step_t rad_step;
    assign rad_step.en    = en;
    assign rad_step.valid = c_vld_reg;

    logic          r_vld;
    logic [RW-1:0] r_ref, r_oth;
    logic [1:0]    r_img;
    logic          r_oth_vld;
    logic [1:0]    r_oth_pay;

    rdr_isqrt #(.ROOT_W(RW), .PAY_W(2)) u_sqrt_ref (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_step     (rad_step),
        .in_radicand (c_ref_reg),
        .in_pay      (c_img_reg),
        .out_valid   (r_vld),
        .out_root    (r_ref),
        .out_pay     (r_img)
    );

    rdr_isqrt #(.ROOT_W(RW), .PAY_W(2)) u_sqrt_oth (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_step     (rad_step),
        .in_radicand (c_oth_reg),
        .in_pay      (c_img_reg),
        .out_valid   (r_oth_vld),
        .out_root    (r_oth),
        .out_pay     (r_oth_pay)
    );

    // ---------------- normalisation u = (r << 16) / base ----------------
    logic          d0_vld_reg, d0_sat_reg;
    logic [18:0]   d0_rem_reg;
    logic [QW-1:0] d0_low_reg;
    logic [1:0]    d0_img_reg;
    logic [RW-1:0] d0_oth_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // quotient would not fit in 24 bits
            d0_sat_reg <= ({5'b0, r_ref} >= {base, 8'b0});
            d0_rem_reg <= {5'b0, r_ref[RW-1:8]};
            d0_low_reg <= {r_ref[7:0], 16'b0};
            d0_img_reg <= r_img;
            d0_oth_reg <= r_oth;
        end
    end

    logic          dv_vld_reg [QW];
    logic          dv_sat_reg [QW];
    logic [18:0]   dv_rem_reg [QW];
    logic [QW-1:0] dv_low_reg [QW];
    logic [QW-1:0] dv_q_reg   [QW];
    logic [1:0]    dv_img_reg [QW];
    logic [RW-1:0] dv_oth_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic          vld_src, sat_src;
        logic [18:0]   rem_src;
        logic [QW-1:0] low_src, q_src;
        logic [1:0]    img_src;
        logic [RW-1:0] oth_src;
        logic [19:0]   rem_sh;
        logic          ge;

        if (j == 0) begin : g_first
            assign vld_src = d0_vld_reg;
            assign sat_src = d0_sat_reg;
            assign rem_src = d0_rem_reg;
            assign low_src = d0_low_reg;
            assign q_src   = '0;
            assign img_src = d0_img_reg;
            assign oth_src = d0_oth_reg;
        end else begin : g_next
            assign vld_src = dv_vld_reg[j-1];
            assign sat_src = dv_sat_reg[j-1];
            assign rem_src = dv_rem_reg[j-1];
            assign low_src = dv_low_reg[j-1];
            assign q_src   = dv_q_reg[j-1];
            assign img_src = dv_img_reg[j-1];
            assign oth_src = dv_oth_reg[j-1];
        end

        assign rem_sh = {rem_src, low_src[QW-1]};
        assign ge     = rem_sh >= {1'b0, base};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[j] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_sat_reg[j] <= sat_src;
                dv_rem_reg[j] <= ge ? 19'(rem_sh - {1'b0, base}) : rem_sh[18:0];
                dv_low_reg[j] <= low_src << 1;
                dv_q_reg[j]   <= {q_src[QW-2:0], ge};
                dv_img_reg[j] <= img_src;
                dv_oth_reg[j] <= oth_src;
            end
        end
    end

    // ---------------- Horner setup ----------------
    logic [1:0]  dv_sel;
    logic [15:0] coef_a;
    assign dv_sel = (dv_img_reg[QW-1] == 2'd3) ? 2'd2 : dv_img_reg[QW-1];
    assign coef_a = coeffs_reg[dv_sel][63:48];

    logic               h0_vld_reg;
    logic signed [38:0] h0_acc_reg;
    hside_t             h0_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            h0_acc_reg        <= {{19{coef_a[15]}}, coef_a, 4'b0};
            h0_side_reg.u     <= dv_sat_reg[QW-1] ? {QW{1'b1}} : dv_q_reg[QW-1];
            h0_side_reg.img   <= dv_img_reg[QW-1];
            h0_side_reg.r_oth <= dv_oth_reg[QW-1];
        end
    end

    // ---------------- Horner: multiply, round, add and clamp ----------------
    logic               hm_vld_reg  [4];
    logic signed [63:0] hm_prod_reg [4];
    hside_t             hm_side_reg [4];
    logic               hr_vld_reg  [4];
    logic signed [47:0] hr_val_reg  [4];
    hside_t             hr_side_reg [4];
    logic               ha_vld_reg  [4];
    logic signed [38:0] ha_acc_reg  [4];
    hside_t             ha_side_reg [4];

    for (genvar j = 0; j < 4; j++) begin : g_horner
        logic               vld_src;
        logic signed [38:0] acc_src;
        hside_t             side_src;
        logic signed [63:0] rnd;
        logic signed [48:0] sum;
        logic [1:0]         sel;
        logic [15:0]        k;

        if (j == 0) begin : g_first
            assign vld_src  = h0_vld_reg;
            assign acc_src  = h0_acc_reg;
            assign side_src = h0_side_reg;
        end else begin : g_next
            assign vld_src  = ha_vld_reg[j-1];
            assign acc_src  = ha_acc_reg[j-1];
            assign side_src = ha_side_reg[j-1];
        end

        assign sel = (hr_side_reg[j].img == 2'd3) ? 2'd2 : hr_side_reg[j].img;
        if (j < 3) begin : g_coef
            assign k = coeffs_reg[sel][16*(2-j) +: 16];
        end else begin : g_nocoef
            assign k = '0;
        end

        // round half away from zero on the 16 dropped bits
        assign rnd = hm_prod_reg[j] + (hm_prod_reg[j][63] ? 64'sd32767 : 64'sd32768);
        assign sum = hr_val_reg[j] + $signed({{29{k[15]}}, k, 4'b0});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hm_vld_reg[j] <= 1'b0;
                hr_vld_reg[j] <= 1'b0;
                ha_vld_reg[j] <= 1'b0;
            end else if (en) begin
                hm_vld_reg[j] <= vld_src;
                hr_vld_reg[j] <= hm_vld_reg[j];
                ha_vld_reg[j] <= hr_vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                hm_prod_reg[j] <= acc_src * $signed({1'b0, side_src.u});
                hm_side_reg[j] <= side_src;
                hr_val_reg[j]  <= rnd[63:16];
                hr_side_reg[j] <= hm_side_reg[j];
                if (sum > ACC_HI) begin
                    ha_acc_reg[j] <= ACC_HI[38:0];
                end else if (sum < ACC_LO) begin
                    ha_acc_reg[j] <= ACC_LO[38:0];
                end else begin
                    ha_acc_reg[j] <= sum[38:0];
                end
                ha_side_reg[j] <= hr_side_reg[j];
            end
        end
    end

    // ---------------- scale back to pixels ----------------
    logic               cm_vld_reg, cr_vld_reg;
    logic signed [58:0] cm_prod_reg;
    logic signed [42:0] cr_val_reg;
    logic [RW-1:0]      cm_oth_reg, cr_oth_reg;
    logic signed [58:0] crnd;
    assign crnd = cm_prod_reg + (cm_prod_reg[58] ? 59'sd32767 : 59'sd32768);

    always_ff @(posedge aclk) begin
        if (en) begin
            cm_prod_reg <= ha_acc_reg[3] * $signed({1'b0, base});
            cm_oth_reg  <= ha_side_reg[3].r_oth;
            cr_val_reg  <= crnd[58:16];
            cr_oth_reg  <= cm_oth_reg;
        end
    end

    // ---------------- difference, magnitude, Huber set-up ----------------
    logic               df_vld_reg;
    logic signed [43:0] df_diff_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            df_diff_reg <= cr_val_reg - $signed({22'b0, cr_oth_reg});
        end
    end

    logic [43:0] df_neg_diff;
    logic [42:0] mag;
    assign df_neg_diff = -df_diff_reg;
    assign mag = df_diff_reg[43] ? df_neg_diff[42:0] : df_diff_reg[42:0];

    logic        mg_vld_reg, mg_big_reg, mg_neg_reg;
    logic [42:0] mg_mag_reg;
    logic [23:0] mg_lin_reg;
    logic [22:0] mg_abs_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mg_mag_reg <= mag;
            mg_neg_reg <= df_diff_reg[43];
            mg_big_reg <= (huber_sigma_reg != 16'd0) && (mag > {27'b0, huber_sigma_reg});
            mg_abs_reg <= (mag > 43'd8388607) ? 23'h7FFFFF : mag[22:0];
            if (df_diff_reg > 44'sd8388607) begin
                mg_lin_reg <= RES_MAX;
            end else if (df_diff_reg < -44'sd8388608) begin
                mg_lin_reg <= RES_MIN;
            end else begin
                mg_lin_reg <= df_diff_reg[23:0];
            end
        end
    end

    logic        t_vld_reg, t_big_reg, t_neg_reg;
    logic [43:0] t_val_reg;
    logic [23:0] t_lin_reg;
    logic [22:0] t_abs_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t_val_reg <= {mg_mag_reg, 1'b0} - {28'b0, huber_sigma_reg};
            t_big_reg <= mg_big_reg;
            t_neg_reg <= mg_neg_reg;
            t_lin_reg <= mg_lin_reg;
            t_abs_reg <= mg_abs_reg;
        end
    end

    logic          p_vld_reg;
    logic [2*HW-1:0] p_val_reg;
    logic [48:0]   p_pay_reg;       // neg, big, linear residual, abs error
    logic [58:0]   hprod;
    assign hprod = huber_sigma_reg * t_val_reg[42:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_val_reg <= {1'b0, hprod};
            p_pay_reg <= {t_neg_reg, t_big_reg, t_lin_reg, t_abs_reg};
        end
    end

    // ---------------- Huber weight ----------------
    rdr_pkg::rdr_step_t hub_step;
    assign hub_step.en    = en;
    assign hub_step.valid = p_vld_reg;

    logic          w_vld;
    logic [HW-1:0] w_root;
    logic [48:0]   w_pay;

    rdr_isqrt #(.ROOT_W(HW), .PAY_W(49)) u_sqrt_huber (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_step     (hub_step),
        .in_radicand (p_val_reg),
        .in_pay      (p_pay_reg),
        .out_valid   (w_vld),
        .out_root    (w_root),
        .out_pay     (w_pay)
    );

    logic [HW-1:0] w_negv;
    logic [23:0]   res_w, res_out;
    assign w_negv = -w_root;
    always_comb begin
        if (w_pay[48]) begin
            res_w = (w_root >= 30'd8388608) ? RES_MIN : w_negv[23:0];
        end else begin
            res_w = (w_root > 30'd8388607) ? RES_MAX : w_root[23:0];
        end
        res_out = w_pay[47] ? res_w : w_pay[46:23];
    end

    // ---------------- valid chain and output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            c_vld_reg    <= 1'b0;
            d0_vld_reg   <= 1'b0;
            h0_vld_reg   <= 1'b0;
            cm_vld_reg   <= 1'b0;
            cr_vld_reg   <= 1'b0;
            df_vld_reg   <= 1'b0;
            mg_vld_reg   <= 1'b0;
            t_vld_reg    <= 1'b0;
            p_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg    <= s_tvalid;
            b_vld_reg    <= a_vld_reg;
            c_vld_reg    <= b_vld_reg;
            d0_vld_reg   <= r_vld;
            h0_vld_reg   <= dv_vld_reg[QW-1];
            cm_vld_reg   <= ha_vld_reg[3];
            cr_vld_reg   <= cm_vld_reg;
            df_vld_reg   <= cr_vld_reg;
            mg_vld_reg   <= df_vld_reg;
            t_vld_reg    <= mg_vld_reg;
            p_vld_reg    <= t_vld_reg;
            m_tvalid_reg <= w_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {1'b0, w_pay[22:0], res_out};
        end
    end

    // ---------------- checks ----------------
    logic [23:0] out_res;
    logic [22:0] out_abs;
    logic [23:0] out_res_neg;
    logic [23:0] out_res_mag;
    assign out_res     = m_tdata_reg[23:0];
    assign out_abs     = m_tdata_reg[46:24];
    assign out_res_neg = -out_res;
    assign out_res_mag = out_res[23] ? out_res_neg : out_res;

    a_zero_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((out_res == 24'd0) == (out_abs == 23'd0)))
        else $error("residual and abs error disagree on zero");

    a_weight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (out_res != RES_MIN) |-> (out_res_mag <= {1'b0, out_abs}))
        else $error("weighted residual exceeds abs error");

    a_unweighted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (huber_sigma_reg == 16'd0) && (out_res != RES_MIN)
        |-> (out_res_mag == {1'b0, out_abs}))
        else $error("unweighted residual differs from abs error");

    a_side_align: assert property (@(posedge aclk) disable iff (!aresetn)
        (r_vld == r_oth_vld) && (!r_vld || (r_oth_pay == r_img)))
        else $error("radius pipelines out of step");

endmodule
